// ----- src/ptlp_pkg.sv -----
package ptlp_pkg;

    localparam int CoordW = 32;
    localparam int DiffW  = 33;
    localparam int ProdW  = 66;
    localparam int NumW   = 68;
    localparam int DenW   = 66;
    localparam int HalfW  = 33;
    localparam int MW     = 99;
    localparam int NW     = 101;
    localparam int DW     = 67;
    localparam int QB     = 36;
    localparam int OffW   = 35;
    localparam int SumW   = 36;

    localparam logic [QB-1:0]   OffClamp = QB'(64'd1 << 34);
    localparam logic [SumW-1:0] SatMax   = SumW'(64'h7FFF_FFFF);
    localparam logic [SumW-1:0] SatMin   = SumW'(64'hFFFF_FFFF_8000_0000);

    typedef struct packed {
        logic [2:0][DiffW-1:0]  d;
        logic [2:0][DiffW-1:0]  w;
        logic [2:0][CoordW-1:0] anc;
    } ptlp_item_t;

    localparam int ItemW = $bits(ptlp_item_t);

    typedef struct packed {
        logic [2:0]             neg;
        logic                   deg;
        logic [2:0][CoordW-1:0] anc;
    } ptlp_side_t;

endpackage

// ----- src/ptlp_front.sv -----
module ptlp_front
    import ptlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [2:0][CoordW-1:0] pt,
    input  logic [2:0][CoordW-1:0] anc,
    input  logic [2:0][CoordW-1:0] sec,
    output logic                   q_valid,
    output ptlp_item_t             q_item,
    input  logic                   q_ready
);

    ptlp_item_t item_reg;
    ptlp_item_t item_next;
    logic       valid_reg;
    logic       valid_next;
    logic       accept;

    assign in_ready = !valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        logic [DiffW-1:0] a;
        logic [DiffW-1:0] s;
        logic [DiffW-1:0] p;
        for (int i = 0; i < 3; i++)
        begin
            a = {anc[i][CoordW-1], anc[i]};
            s = {sec[i][CoordW-1], sec[i]};
            p = {pt[i][CoordW-1], pt[i]};
            item_next.anc[i] = anc[i];
            item_next.d[i]   = op ? s : s - a;
            item_next.w[i]   = p - a;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/ptlp_fifo.sv -----
module ptlp_fifo
    import ptlp_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    wptr_next;
    logic [AW-1:0]    rptr_reg;
    logic [AW-1:0]    rptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (AW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ----- src/ptlp_divider.sv -----
module ptlp_divider
    import ptlp_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] n_in,
    input  logic [DW-1:0] d_in,
    output logic [QB-1:0] q_out,
    output logic          ovf_out
);

    localparam int CW = DW + QB + 1;

    logic [NW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_in;
            den_reg[0] <= d_in;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CW'(n_in) >= (CW'(d_in) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        localparam int Sh = QB - j;
        logic [CW-1:0] r_ext;
        logic [CW-1:0] d_sh;
        logic          ge;

        assign r_ext = CW'(rem_reg[j-1]);
        assign d_sh  = CW'(den_reg[j-1]) << Sh;
        assign ge    = r_ext >= d_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]   <= q_reg[j-1] | (ge ? (QB'(1) << Sh) : '0);
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? NW'(r_ext - d_sh) : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign q_out   = q_reg[QB];
    assign ovf_out = ovf_reg[QB];

endmodule

// ----- src/ptlp_back.sv -----
module ptlp_back
    import ptlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ptlp_item_t             in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0][CoordW-1:0] proj,
    output logic                   degenerate
);

    localparam int DivLat = QB + 1;

    logic en;

    logic                         v1_reg;
    logic signed [ProdW-1:0]      prod1_reg [3];
    logic        [ProdW-1:0]      sq1_reg   [3];
    logic [2:0][DiffW-1:0]        dmag1_reg;
    logic [2:0]                   dneg1_reg;
    logic [2:0][CoordW-1:0]       anc1_reg;

    logic                         v2_reg;
    logic [DenW-1:0]              nmag2_reg;
    logic                         nneg2_reg;
    logic [DenW-1:0]              den2_reg;
    logic [2:0][DiffW-1:0]        dmag2_reg;
    logic [2:0]                   dneg2_reg;
    logic [2:0][CoordW-1:0]       anc2_reg;

    logic                         v3_reg;
    logic [ProdW-1:0]             pl3_reg [3];
    logic [ProdW-1:0]             ph3_reg [3];
    logic [DenW-1:0]              den3_reg;
    ptlp_side_t                   side3_reg;

    logic                         v4_reg;
    logic [NW-1:0]                n4_reg [3];
    logic [DW-1:0]                d4_reg;
    ptlp_side_t                   side4_reg;

    logic                         sv_reg   [DivLat];
    ptlp_side_t                   side_reg [DivLat];

    logic [QB-1:0]                q_div   [3];
    logic                         ovf_div [3];

    logic                         out_valid_reg;
    logic [2:0][CoordW-1:0]       proj_reg;
    logic [2:0][CoordW-1:0]       proj_next;
    logic                         deg_reg;

    assign en         = !out_valid_reg || out_ready;
    assign in_ready   = en;
    assign out_valid  = out_valid_reg;
    assign proj       = proj_reg;
    assign degenerate = deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DivLat; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            sv_reg[0]     <= v4_reg;
            for (int k = 1; k < DivLat; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
            out_valid_reg <= sv_reg[DivLat-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [DiffW-1:0] ds;
        logic signed [DiffW-1:0] ws;
        logic        [DiffW-1:0] dm;
        logic signed [NumW-1:0]  num;
        logic        [NumW-1:0]  nabs;
        logic        [DenW-1:0]  den;
        logic        [MW-1:0]    m;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ds = $signed(in_item.d[i]);
                ws = $signed(in_item.w[i]);
                dm = ds[DiffW-1] ? DiffW'(0) - in_item.d[i] : in_item.d[i];
                prod1_reg[i] <= ProdW'(ds) * ProdW'(ws);
                sq1_reg[i]   <= ProdW'(dm) * ProdW'(dm);
                dmag1_reg[i] <= dm;
                dneg1_reg[i] <= ds[DiffW-1];
            end
            anc1_reg <= in_item.anc;

            num = NumW'(prod1_reg[0]) + NumW'(prod1_reg[1]) + NumW'(prod1_reg[2]);
            den = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            nabs = num[NumW-1] ? NumW'(0) - NumW'(num) : NumW'(num);
            nmag2_reg <= nabs[DenW-1:0];
            nneg2_reg <= num[NumW-1];
            den2_reg  <= den;
            dmag2_reg <= dmag1_reg;
            dneg2_reg <= dneg1_reg;
            anc2_reg  <= anc1_reg;

            for (int i = 0; i < 3; i++)
            begin
                pl3_reg[i] <= ProdW'(nmag2_reg[HalfW-1:0]) * ProdW'(dmag2_reg[i]);
                ph3_reg[i] <= ProdW'(nmag2_reg[DenW-1:HalfW]) * ProdW'(dmag2_reg[i]);
                side3_reg.neg[i] <= dneg2_reg[i] ^ nneg2_reg;
            end
            den3_reg      <= den2_reg;
            side3_reg.deg <= den2_reg == '0;
            side3_reg.anc <= anc2_reg;

            for (int i = 0; i < 3; i++)
            begin
                m = MW'(pl3_reg[i]) + (MW'(ph3_reg[i]) << HalfW);
                n4_reg[i] <= (NW'(m) << 1) + NW'(den3_reg);
            end
            d4_reg    <= DW'(den3_reg) << 1;
            side4_reg <= side3_reg;

            side_reg[0] <= side4_reg;
            for (int k = 1; k < DivLat; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            proj_reg <= proj_next;
            deg_reg  <= side_reg[DivLat-1].deg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        ptlp_divider u_div
        (
            .clk     (clk),
            .en      (en),
            .n_in    (n4_reg[i]),
            .d_in    (d4_reg),
            .q_out   (q_div[i]),
            .ovf_out (ovf_div[i])
        );
    end

    always_comb
    begin
        logic [OffW-1:0] qm;
        logic [SumW-1:0] off;
        logic [SumW-1:0] sum;
        ptlp_side_t      sd;
        sd = side_reg[DivLat-1];
        for (int i = 0; i < 3; i++)
        begin
            qm  = (ovf_div[i] || q_div[i] > OffClamp) ? OffClamp[OffW-1:0]
                                                      : q_div[i][OffW-1:0];
            off = sd.neg[i] ? SumW'(0) - SumW'(qm) : SumW'(qm);
            sum = SumW'($signed(sd.anc[i])) + off;
            if (sd.deg)
            begin
                proj_next[i] = sd.anc[i];
            end
            else if ($signed(sum) > $signed(SatMax))
            begin
                proj_next[i] = SatMax[CoordW-1:0];
            end
            else if ($signed(sum) < $signed(SatMin))
            begin
                proj_next[i] = SatMin[CoordW-1:0];
            end
            else
            begin
                proj_next[i] = sum[CoordW-1:0];
            end
        end
    end

endmodule

// ----- src/point_to_line_projection_top.sv -----
// Projects a 3D point orthogonally onto a line, all coordinates signed Q16.16.
// Input channel s_*: one item carries the point, the line anchor and a second
// group that is a second line point (s_tuser = 0) or a direction (s_tuser = 1).
// Output channel m_*: one item per input item, in order, with the projected
// point (saturated to the Q16.16 range) and a flag in m_tuser that is set when
// the line direction is zero; the anchor is then returned unchanged.
// An input stage forms the direction and offset vectors and feeds a small
// queue; the back pipeline computes the dot products, scales the numerator and
// runs three pipelined restoring dividers of one quotient bit per stage.
// Most of the latency comes from the 37 divider stages. One item is accepted
// every cycle when m_tready stays high. When the receiver holds m_tready low
// while m_tvalid is high, the back pipeline freezes, the queue fills, and
// s_tready drops once the queue and input stage are full. Reset empties the
// pipeline and the queue; outside reset no item is lost or repeated.
module point_to_line_projection_top
    import ptlp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, anchor_x, anchor_y, anchor_z,
    // second_x, second_y, second_z
    input  logic [287:0] s_tdata,
    // op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // proj_x, proj_y, proj_z
    output logic [95:0]  m_tdata,
    // degenerate
    output logic         m_tuser
);

    logic [2:0][CoordW-1:0] pt;
    logic [2:0][CoordW-1:0] anc;
    logic [2:0][CoordW-1:0] sec;
    logic [2:0][CoordW-1:0] proj;
    logic                   fq_valid;
    logic                   fq_ready;
    ptlp_item_t             fq_item;
    logic                   qb_valid;
    logic                   qb_ready;
    logic [ItemW-1:0]       qb_data;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt[i]  = s_tdata[CoordW*i +: CoordW];
            anc[i] = s_tdata[CoordW*(3+i) +: CoordW];
            sec[i] = s_tdata[CoordW*(6+i) +: CoordW];
            m_tdata[CoordW*i +: CoordW] = proj[i];
        end
    end

    ptlp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op       (s_tuser),
        .pt       (pt),
        .anc      (anc),
        .sec      (sec),
        .q_valid  (fq_valid),
        .q_item   (fq_item),
        .q_ready  (fq_ready)
    );

    ptlp_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ItemW)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    ptlp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_item    (ptlp_item_t'(qb_data)),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .proj       (proj),
        .degenerate (m_tuser)
    );

endmodule
